/* hw/rtl/tlas_pkg.sv */
package tlas_pkg;

   localparam int unsigned ATAN_ENTRIES = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [29:0] RAD_TO_ANGLE = 30'd683565276;

   // register indexes
   localparam logic [2:0] REG_INIT_ONE   = 3'd0;
   localparam logic [2:0] REG_INIT_TWO   = 3'd1;
   localparam logic [2:0] REG_RABI_FREQ  = 3'd2;
   localparam logic [2:0] REG_DECAY_RATE = 3'd3;
   localparam logic [2:0] REG_TIME_STEP  = 3'd4;
   localparam logic [2:0] REG_DETUNING   = 3'd5;
   localparam logic [2:0] REG_LEVEL_FREQ = 3'd6;

   localparam logic [31:0] RESET_INIT_ONE  = 32'd268435456;
   localparam logic [31:0] RESET_INIT_TWO  = 32'd0;
   localparam logic [31:0] RESET_RABI_FREQ = 32'd65536;
   localparam logic [31:0] RESET_DECAY     = 32'd0;
   localparam logic [31:0] RESET_TIME_STEP = 32'd66;
   localparam logic [31:0] RESET_DETUNING  = 32'd0;
   localparam logic [31:0] RESET_LEVEL     = 32'd0;

   // product schedule
   localparam logic [4:0] OP_FIRST      = 5'd0;
   localparam logic [4:0] OP_LAST_TERM  = 5'd23;
   localparam logic [4:0] OP_FIRST_POP  = 5'd24;
   localparam logic [4:0] OP_LAST       = 5'd27;

   // accumulator slots holding the squared magnitudes
   localparam logic [2:0] ACC_POP_ONE = 3'd4;
   localparam logic [2:0] ACC_POP_TWO = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_PH_MUL, ST_PH_LO, ST_PH_HI, ST_COR_INIT, ST_COR_STEP,
      ST_COR_DONE, ST_M_OPND, ST_M_LO, ST_M_HI, ST_M_SUM, ST_M_ACC, ST_COMMIT,
      ST_POP, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      B_COS, B_SIN, B_RABI, B_DECAY, B_STEP, B_LEVEL, B_AMP
   } bsel_type;

   typedef enum logic [1:0] {
      SH_0, SH_16, SH_17, SH_30
   } shift_type;

   typedef struct packed {
      logic       a_acc;
      logic [2:0] a_idx;
      bsel_type   b_sel;
      shift_type  shift;
      logic       sub;
      logic [2:0] dest;
      logic       clear;
      logic       base;
   } op_type;

   typedef struct packed {
      logic       start;
      logic       load;
      logic       ph_mul;
      logic       ph_lo;
      logic       ph_hi;
      logic       cor_init;
      logic       cor_step;
      logic       cor_done;
      logic       m_opnd;
      logic       m_lo;
      logic       m_hi;
      logic       m_sum;
      logic       m_acc;
      logic       commit;
      logic       pop;
      logic       load_out;
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic cor_last;
   } status_type;

   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      case (idx)
         5'd0:  atan_angle = 32'h20000000;
         5'd1:  atan_angle = 32'h12E4051E;
         5'd2:  atan_angle = 32'h09FB385B;
         5'd3:  atan_angle = 32'h051111D4;
         5'd4:  atan_angle = 32'h028B0D43;
         5'd5:  atan_angle = 32'h0145D7E1;
         5'd6:  atan_angle = 32'h00A2F61E;
         5'd7:  atan_angle = 32'h00517C55;
         5'd8:  atan_angle = 32'h0028BE53;
         5'd9:  atan_angle = 32'h00145F2F;
         5'd10: atan_angle = 32'h000A2F98;
         5'd11: atan_angle = 32'h000517CC;
         5'd12: atan_angle = 32'h00028BE6;
         5'd13: atan_angle = 32'h000145F3;
         5'd14: atan_angle = 32'h0000A2FA;
         5'd15: atan_angle = 32'h0000517D;
         5'd16: atan_angle = 32'h000028BE;
         5'd17: atan_angle = 32'h0000145F;
         5'd18: atan_angle = 32'h00000A30;
         5'd19: atan_angle = 32'h00000518;
         5'd20: atan_angle = 32'h0000028C;
         5'd21: atan_angle = 32'h00000146;
         5'd22: atan_angle = 32'h000000A3;
         5'd23: atan_angle = 32'h00000051;
         5'd24: atan_angle = 32'h00000029;
         5'd25: atan_angle = 32'h00000014;
         5'd26: atan_angle = 32'h0000000A;
         5'd27: atan_angle = 32'h00000005;
         5'd28: atan_angle = 32'h00000003;
         5'd29: atan_angle = 32'h00000001;
         default: atan_angle = 32'h00000000;
      endcase
   endfunction

   // a source (amplitude or accumulator), b source, shift, subtract, destination,
   // clear destination first, seed destination with an amplitude
   function automatic op_type op_entry(input logic [4:0] op);
      case (op)
         5'd0:  op_entry = '{1'b0, 3'd2, B_COS,   SH_30, 1'b0, 3'd0, 1'b1, 1'b0};
         5'd1:  op_entry = '{1'b0, 3'd3, B_SIN,   SH_30, 1'b1, 3'd0, 1'b0, 1'b0};
         5'd2:  op_entry = '{1'b0, 3'd2, B_SIN,   SH_30, 1'b0, 3'd1, 1'b1, 1'b0};
         5'd3:  op_entry = '{1'b0, 3'd3, B_COS,   SH_30, 1'b0, 3'd1, 1'b0, 1'b0};
         5'd4:  op_entry = '{1'b0, 3'd0, B_COS,   SH_30, 1'b0, 3'd2, 1'b1, 1'b0};
         5'd5:  op_entry = '{1'b0, 3'd1, B_SIN,   SH_30, 1'b0, 3'd2, 1'b0, 1'b0};
         5'd6:  op_entry = '{1'b0, 3'd1, B_COS,   SH_30, 1'b0, 3'd3, 1'b1, 1'b0};
         5'd7:  op_entry = '{1'b0, 3'd0, B_SIN,   SH_30, 1'b1, 3'd3, 1'b0, 1'b0};
         5'd8:  op_entry = '{1'b1, 3'd1, B_RABI,  SH_16, 1'b1, 3'd4, 1'b1, 1'b0};
         5'd9:  op_entry = '{1'b0, 3'd1, B_LEVEL, SH_16, 1'b0, 3'd4, 1'b0, 1'b0};
         5'd10: op_entry = '{1'b0, 3'd0, B_DECAY, SH_17, 1'b1, 3'd4, 1'b0, 1'b0};
         5'd11: op_entry = '{1'b1, 3'd0, B_RABI,  SH_16, 1'b0, 3'd5, 1'b1, 1'b0};
         5'd12: op_entry = '{1'b0, 3'd0, B_LEVEL, SH_16, 1'b1, 3'd5, 1'b0, 1'b0};
         5'd13: op_entry = '{1'b0, 3'd1, B_DECAY, SH_17, 1'b1, 3'd5, 1'b0, 1'b0};
         5'd14: op_entry = '{1'b1, 3'd3, B_RABI,  SH_16, 1'b1, 3'd6, 1'b1, 1'b0};
         5'd15: op_entry = '{1'b0, 3'd3, B_LEVEL, SH_16, 1'b0, 3'd6, 1'b0, 1'b0};
         5'd16: op_entry = '{1'b0, 3'd2, B_DECAY, SH_17, 1'b1, 3'd6, 1'b0, 1'b0};
         5'd17: op_entry = '{1'b1, 3'd2, B_RABI,  SH_16, 1'b0, 3'd7, 1'b1, 1'b0};
         5'd18: op_entry = '{1'b0, 3'd2, B_LEVEL, SH_16, 1'b1, 3'd7, 1'b0, 1'b0};
         5'd19: op_entry = '{1'b0, 3'd3, B_DECAY, SH_17, 1'b1, 3'd7, 1'b0, 1'b0};
         5'd20: op_entry = '{1'b1, 3'd4, B_STEP,  SH_16, 1'b0, 3'd0, 1'b1, 1'b1};
         5'd21: op_entry = '{1'b1, 3'd5, B_STEP,  SH_16, 1'b0, 3'd1, 1'b1, 1'b1};
         5'd22: op_entry = '{1'b1, 3'd6, B_STEP,  SH_16, 1'b0, 3'd2, 1'b1, 1'b1};
         5'd23: op_entry = '{1'b1, 3'd7, B_STEP,  SH_16, 1'b0, 3'd3, 1'b1, 1'b1};
         5'd24: op_entry = '{1'b0, 3'd0, B_AMP,   SH_0,  1'b0, 3'd4, 1'b1, 1'b0};
         5'd25: op_entry = '{1'b0, 3'd1, B_AMP,   SH_0,  1'b0, 3'd4, 1'b0, 1'b0};
         5'd26: op_entry = '{1'b0, 3'd2, B_AMP,   SH_0,  1'b0, 3'd5, 1'b1, 1'b0};
         5'd27: op_entry = '{1'b0, 3'd3, B_AMP,   SH_0,  1'b0, 3'd5, 1'b0, 1'b0};
         default: op_entry = '{1'b0, 3'd0, B_COS, SH_0, 1'b0, 3'd0, 1'b0, 1'b0};
      endcase
   endfunction

endpackage

/* hw/rtl/tlas_controller.sv */
module tlas_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_restart,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tlas_pkg::cmd_type    cmd,
   input  tlas_pkg::status_type status
);
   import tlas_pkg::*;

   state_type  state_ff, state_in;
   logic [4:0] op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_restart ? ST_LOAD : ST_PH_MUL;
            end
         end
         ST_LOAD: begin
            op_in    = OP_FIRST_POP;
            state_in = ST_M_OPND;
         end
         ST_PH_MUL:   state_in = ST_PH_LO;
         ST_PH_LO:    state_in = ST_PH_HI;
         ST_PH_HI:    state_in = ST_COR_INIT;
         ST_COR_INIT: state_in = ST_COR_STEP;
         ST_COR_STEP: begin
            if (status.cor_last) begin
               state_in = ST_COR_DONE;
            end
         end
         ST_COR_DONE: begin
            op_in    = OP_FIRST;
            state_in = ST_M_OPND;
         end
         ST_M_OPND: state_in = ST_M_LO;
         ST_M_LO:   state_in = ST_M_HI;
         ST_M_HI:   state_in = ST_M_SUM;
         ST_M_SUM:  state_in = ST_M_ACC;
         ST_M_ACC: begin
            if (op_ff == OP_LAST_TERM) begin
               state_in = ST_COMMIT;
            end else if (op_ff == OP_LAST) begin
               state_in = ST_POP;
            end else begin
               op_in    = op_ff + 5'd1;
               state_in = ST_M_OPND;
            end
         end
         ST_COMMIT: begin
            op_in    = OP_FIRST_POP;
            state_in = ST_M_OPND;
         end
         ST_POP: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE:     cmd.start    = req_valid;
         ST_LOAD:     cmd.load     = 1'b1;
         ST_PH_MUL:   cmd.ph_mul   = 1'b1;
         ST_PH_LO:    cmd.ph_lo    = 1'b1;
         ST_PH_HI:    cmd.ph_hi    = 1'b1;
         ST_COR_INIT: cmd.cor_init = 1'b1;
         ST_COR_STEP: cmd.cor_step = 1'b1;
         ST_COR_DONE: cmd.cor_done = 1'b1;
         ST_M_OPND:   cmd.m_opnd   = 1'b1;
         ST_M_LO:     cmd.m_lo     = 1'b1;
         ST_M_HI:     cmd.m_hi     = 1'b1;
         ST_M_SUM:    cmd.m_sum    = 1'b1;
         ST_M_ACC:    cmd.m_acc    = 1'b1;
         ST_COMMIT:   cmd.commit   = 1'b1;
         ST_POP:      cmd.pop      = 1'b1;
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/tlas_datapath.sv */
module tlas_datapath #(
   parameter int AMP_FRAC_BITS = 28,
   parameter int CORDIC_STEPS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tlas_pkg::cmd_type    cmd,
   output tlas_pkg::status_type status,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   output logic [47:0]          rsp_elapsed,
   output logic [33:0]          rsp_pop_one,
   output logic [33:0]          rsp_pop_two,
   output logic                 rsp_saturated
);
   import tlas_pkg::*;

   localparam int IW = $clog2(CORDIC_STEPS);
   localparam logic [96:0] PRODUCT_CAP = 97'd1 << 62;

   logic [31:0] init_one_ff, init_two_ff, rabi_ff, decay_ff, step_ff, detune_ff, level_ff;

   logic signed [31:0] amp_ff [4];
   logic signed [63:0] acc_ff [8];
   logic [47:0]        time_ff;
   logic [31:0]        phase_ff;
   logic               sat_ff;

   logic [63:0]        inc_ff;
   logic [61:0]        klo_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff, cos_ff, sin_ff;
   logic               flip_ff;
   logic [IW-1:0]      iter_ff;

   logic [63:0] ua_ff;
   logic [32:0] ub_ff;
   logic        neg_ff;
   logic [64:0] lo_ff, hi_ff;
   logic [62:0] mag_ff;
   logic [33:0] pop_one_ff, pop_two_ff;

   op_type             op;
   logic [2:0]         acc_idx;
   logic [1:0]         amp_idx;
   logic signed [63:0] acc_rd, amp_ext, a_val, term, base;
   logic signed [31:0] amp_rd;
   logic signed [33:0] b_val, b_neg;
   logic [96:0]        full, shifted;
   logic [65:0]        inc_full;
   logic [61:0]        khi;
   logic [31:0]        phase_sum, angle;
   logic signed [33:0] shx, shy, atan_ext;
   logic [63:0]        pop_one_sh, pop_two_sh;
   logic [3:0]         clip_hi, clip_lo;

   assign op      = op_entry(cmd.op);
   assign acc_idx = cmd.m_acc ? op.dest : op.a_idx;
   assign amp_idx = cmd.m_acc ? op.dest[1:0] : op.a_idx[1:0];
   assign acc_rd  = acc_ff[acc_idx];
   assign amp_rd  = amp_ff[amp_idx];
   assign amp_ext = {{32{amp_rd[31]}}, amp_rd};
   assign a_val   = op.a_acc ? acc_rd : amp_ext;

   always_comb begin
      case (op.b_sel)
         B_COS:   b_val = cos_ff;
         B_SIN:   b_val = sin_ff;
         B_RABI:  b_val = {{2{rabi_ff[31]}}, rabi_ff};
         B_DECAY: b_val = {{2{decay_ff[31]}}, decay_ff};
         B_STEP:  b_val = {2'b00, step_ff};
         B_LEVEL: b_val = {{2{level_ff[31]}}, level_ff};
         B_AMP:   b_val = {{2{amp_rd[31]}}, amp_rd};
         default: b_val = '0;
      endcase
   end
   assign b_neg = -b_val;

   assign full = {32'd0, lo_ff} + {hi_ff, 32'd0};
   always_comb begin
      case (op.shift)
         SH_0:    shifted = full;
         SH_16:   shifted = full >> 16;
         SH_17:   shifted = full >> 17;
         SH_30:   shifted = full >> 30;
         default: shifted = full;
      endcase
   end

   assign term = (neg_ff ^ op.sub) ? -{1'b0, mag_ff} : {1'b0, mag_ff};
   assign base = op.clear ? (op.base ? amp_ext : 64'sd0) : acc_rd;

   assign inc_full  = 66'($signed({detune_ff[31], detune_ff}) * $signed({1'b0, step_ff}));
   assign khi       = inc_ff[63:32] * RAD_TO_ANGLE;
   assign phase_sum = phase_ff + 32'h4000_0000;
   assign angle     = phase_sum[31] ? (phase_ff ^ 32'h8000_0000) : phase_ff;

   assign shx      = cx_ff >>> iter_ff;
   assign shy      = cy_ff >>> iter_ff;
   assign atan_ext = {2'b00, atan_angle(5'(iter_ff))};
   assign status.cor_last = (iter_ff == IW'(CORDIC_STEPS - 1));

   assign pop_one_sh = acc_ff[ACC_POP_ONE] >> AMP_FRAC_BITS;
   assign pop_two_sh = acc_ff[ACC_POP_TWO] >> AMP_FRAC_BITS;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         clip_hi[i] = acc_ff[i] > 64'sd2147483647;
         clip_lo[i] = acc_ff[i] < -64'sd2147483648;
      end
   end

   // configuration and integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         init_one_ff <= RESET_INIT_ONE;
         init_two_ff <= RESET_INIT_TWO;
         rabi_ff     <= RESET_RABI_FREQ;
         decay_ff    <= RESET_DECAY;
         step_ff     <= RESET_TIME_STEP;
         detune_ff   <= RESET_DETUNING;
         level_ff    <= RESET_LEVEL;
         amp_ff[0]   <= RESET_INIT_ONE;
         amp_ff[1]   <= '0;
         amp_ff[2]   <= RESET_INIT_TWO;
         amp_ff[3]   <= '0;
         time_ff     <= '0;
         phase_ff    <= '0;
         sat_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_INIT_ONE:   init_one_ff <= csr_data;
               REG_INIT_TWO:   init_two_ff <= csr_data;
               REG_RABI_FREQ:  rabi_ff     <= csr_data;
               REG_DECAY_RATE: decay_ff    <= csr_data;
               REG_TIME_STEP:  step_ff     <= csr_data;
               REG_DETUNING:   detune_ff   <= csr_data;
               REG_LEVEL_FREQ: level_ff    <= csr_data;
               default: ;
            endcase
         end
         if (cmd.start) begin
            sat_ff <= 1'b0;
         end
         if (cmd.load) begin
            amp_ff[0] <= init_one_ff;
            amp_ff[1] <= '0;
            amp_ff[2] <= init_two_ff;
            amp_ff[3] <= '0;
            time_ff   <= '0;
            phase_ff  <= '0;
         end
         if (cmd.ph_mul) begin
            time_ff <= time_ff + {16'd0, step_ff};
         end
         if (cmd.ph_hi) begin
            phase_ff <= phase_ff + 32'(klo_ff[61:32]) + khi[31:0];
         end
         if (cmd.commit) begin
            // clip each new amplitude part to 32 bits
            for (int i = 0; i < 4; i++) begin
               if (clip_hi[i]) begin
                  amp_ff[i] <= 32'sh7FFF_FFFF;
               end else if (clip_lo[i]) begin
                  amp_ff[i] <= 32'sh8000_0000;
               end else begin
                  amp_ff[i] <= acc_ff[i][31:0];
               end
            end
            if (|{clip_hi, clip_lo}) begin
               sat_ff <= 1'b1;
            end
         end
         if (cmd.pop && ((|pop_one_sh[63:34]) || (|pop_two_sh[63:34]))) begin
            sat_ff <= 1'b1;
         end
      end
   end

   // phase, rotation and shared product unit
   always_ff @(posedge clock) begin
      if (cmd.ph_mul) begin
         inc_ff <= inc_full[63:0];
      end
      if (cmd.ph_lo) begin
         klo_ff <= inc_ff[31:0] * RAD_TO_ANGLE;
      end
      if (cmd.cor_init) begin
         cx_ff   <= CORDIC_GAIN;
         cy_ff   <= '0;
         cz_ff   <= {{2{angle[31]}}, angle};
         flip_ff <= phase_sum[31];
         iter_ff <= '0;
      end
      if (cmd.cor_step) begin
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - shy;
            cy_ff <= cy_ff + shx;
            cz_ff <= cz_ff - atan_ext;
         end else begin
            cx_ff <= cx_ff + shy;
            cy_ff <= cy_ff - shx;
            cz_ff <= cz_ff + atan_ext;
         end
         iter_ff <= iter_ff + IW'(1);
      end
      if (cmd.cor_done) begin
         cos_ff <= flip_ff ? -cx_ff : cx_ff;
         sin_ff <= flip_ff ? -cy_ff : cy_ff;
      end
      if (cmd.m_opnd) begin
         ua_ff  <= a_val[63] ? (64'd0 - a_val) : a_val;
         ub_ff  <= b_val[33] ? b_neg[32:0] : b_val[32:0];
         neg_ff <= a_val[63] ^ b_val[33];
      end
      if (cmd.m_lo) begin
         lo_ff <= ua_ff[31:0] * ub_ff;
      end
      if (cmd.m_hi) begin
         hi_ff <= ua_ff[63:32] * ub_ff;
      end
      if (cmd.m_sum) begin
         mag_ff <= (shifted > PRODUCT_CAP) ? PRODUCT_CAP[62:0] : shifted[62:0];
      end
      if (cmd.m_acc) begin
         acc_ff[op.dest] <= base + term;
      end
      if (cmd.pop) begin
         pop_one_ff <= (|pop_one_sh[63:34]) ? '1 : pop_one_sh[33:0];
         pop_two_ff <= (|pop_two_sh[63:34]) ? '1 : pop_two_sh[33:0];
      end
      if (cmd.load_out) begin
         rsp_elapsed   <= time_ff;
         rsp_pop_one   <= pop_one_ff;
         rsp_pop_two   <= pop_two_ff;
         rsp_saturated <= sat_ff;
      end
   end

endmodule

/* hw/rtl/two_level_amplitude_stepper_unit.sv */
// Euler stepper for a damped, driven two-level system. A word with restart set
// reloads the initial amplitudes and clears time and phase; otherwise it takes
// one tick of dt. Every word returns elapsed time, both populations and a
// clip flag. A tick first runs the CORDIC iterations, then 28 products through
// one shared product unit (two 32x33 partial products), each through the operand,
// low, high, sum and accumulate steps. A restart runs only the four population
// products. The result register holds one finished word, so the next word is
// taken while it waits.
module two_level_amplitude_stepper_unit #(
   parameter int AMP_FRAC_BITS = 28,
   parameter int CORDIC_STEPS  = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [47:0] rsp_elapsed,
   output logic [33:0] rsp_pop_one,
   output logic [33:0] rsp_pop_two,
   output logic        rsp_saturated,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import tlas_pkg::*;

   cmd_type    cmd;
   status_type status;

   tlas_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .status      (status)
   );

   tlas_datapath #(
      .AMP_FRAC_BITS (AMP_FRAC_BITS),
      .CORDIC_STEPS  (CORDIC_STEPS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_elapsed   (rsp_elapsed),
      .rsp_pop_one   (rsp_pop_one),
      .rsp_pop_two   (rsp_pop_two),
      .rsp_saturated (rsp_saturated)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a word is in progress");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("result load did not raise valid");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_out))
      else $error("valid raised without a result load");

   a_one_stage: assert property (@(posedge clock) disable iff (reset)
      cmd.m_acc |-> !cmd.m_opnd && !cmd.commit && !cmd.pop)
      else $error("overlapping datapath commands");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import tlas_pkg::*;

   localparam int CORDIC_STEPS = 20;
   localparam int SETTLE_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [47:0] elapsed;
      logic [33:0] pop_one;
      logic [33:0] pop_two;
      logic        saturated;
   } result_word_type;

   typedef struct {
      logic            restart;
      logic            known;
      result_word_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [47:0] rsp_elapsed;
   logic [33:0] rsp_pop_one;
   logic [33:0] rsp_pop_two;
   logic        rsp_saturated;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   two_level_amplitude_stepper_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_elapsed(rsp_elapsed), .rsp_pop_one(rsp_pop_one),
      .rsp_pop_two(rsp_pop_two), .rsp_saturated(rsp_saturated),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // predictor copy of the registers and the integrator state
   logic [31:0] csr_copy [0:6];
   logic signed [31:0] c1_re, c1_im, c2_re, c2_im;
   logic [47:0] clock_time;
   logic [31:0] phase_acc;

   result_word_type pending_results[$];
   logic            pending_known[$];
   result_word_type pending_fixed[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  hold_off = 1'b0;
   bit  quiet_mode = 1'b0;
   bit  drained = 1'b0;

   function automatic logic [31:0] atan_of(input int i);
      logic [31:0] t [0:29];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
      return t[i];
   endfunction

   // signed product shifted right, truncated toward zero, magnitude capped at 2^62
   function automatic longint scaled_product(input longint a, input longint b,
                                             input int sh);
      logic          neg;
      logic [63:0]   ua, ub;
      logic [127:0]  full;
      logic [127:0]  r;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      full = {64'd0, ua} * {64'd0, ub};
      r = full >> sh;
      if (r > (128'd1 << 62)) r = 128'd1 << 62;
      return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic logic signed [31:0] clip32(input longint v, inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [33:0] level_population(input logic signed [31:0] re,
                                                    input logic signed [31:0] im,
                                                    inout logic flag);
      logic [63:0] sq, p;
      sq = 64'(longint'(re) * longint'(re)) + 64'(longint'(im) * longint'(im));
      p = sq >> 28;
      if (p > 64'h3_FFFF_FFFF) begin
         flag = 1'b1;
         return 34'h3_FFFF_FFFF;
      end
      return p[33:0];
   endfunction

   task automatic rotate_phase(input logic [31:0] angle, output longint cs,
                               output longint sn);
      longint x, y, z, nx;
      logic flip;
      x = 652032874;
      y = 0;
      flip = ((angle + 32'h40000000) & 32'h80000000) != 0;
      if (flip) angle = angle - 32'h80000000;
      z = longint'($signed(angle));
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(atan_of(i));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(atan_of(i));
         end
         x = nx;
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endtask

   task automatic advance_state(input logic restart, output result_word_type res);
      logic   sat;
      longint w, g, dt, det, w0, a1, b1, a2, b2, cs, sn;
      longint pre, pim, qre, qim, d1re, d1im, d2re, d2im;
      logic [63:0] inc, ang;
      sat = 1'b0;
      if (restart) begin
         c1_re = csr_copy[REG_INIT_ONE];
         c1_im = 0;
         c2_re = csr_copy[REG_INIT_TWO];
         c2_im = 0;
         clock_time = '0;
         phase_acc = '0;
      end else begin
         w = longint'($signed(csr_copy[REG_RABI_FREQ]));
         g = longint'($signed(csr_copy[REG_DECAY_RATE]));
         dt = longint'({32'd0, csr_copy[REG_TIME_STEP]});
         det = longint'($signed(csr_copy[REG_DETUNING]));
         w0 = longint'($signed(csr_copy[REG_LEVEL_FREQ]));
         a1 = c1_re; b1 = c1_im; a2 = c2_re; b2 = c2_im;
         inc = 64'(det * dt);
         clock_time = clock_time + csr_copy[REG_TIME_STEP];
         ang = inc * 64'd683565276;
         phase_acc = phase_acc + ang[63:32];
         rotate_phase(phase_acc, cs, sn);
         pre = scaled_product(a2, cs, 30) - scaled_product(b2, sn, 30);
         pim = scaled_product(a2, sn, 30) + scaled_product(b2, cs, 30);
         qre = scaled_product(a1, cs, 30) + scaled_product(b1, sn, 30);
         qim = scaled_product(b1, cs, 30) - scaled_product(a1, sn, 30);
         d1re = -scaled_product(w, pim, 16) + scaled_product(w0, b1, 16)
                - scaled_product(g, a1, 17);
         d1im = scaled_product(w, pre, 16) - scaled_product(w0, a1, 16)
                - scaled_product(g, b1, 17);
         d2re = -scaled_product(w, qim, 16) + scaled_product(w0, b2, 16)
                - scaled_product(g, a2, 17);
         d2im = scaled_product(w, qre, 16) - scaled_product(w0, a2, 16)
                - scaled_product(g, b2, 17);
         c1_re = clip32(a1 + scaled_product(d1re, dt, 16), sat);
         c1_im = clip32(b1 + scaled_product(d1im, dt, 16), sat);
         c2_re = clip32(a2 + scaled_product(d2re, dt, 16), sat);
         c2_im = clip32(b2 + scaled_product(d2im, dt, 16), sat);
      end
      res.elapsed = clock_time;
      res.pop_one = level_population(c1_re, c1_im, sat);
      res.pop_two = level_population(c2_re, c2_im, sat);
      res.saturated = sat;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // hold the write enable; stop_writes drops it after the last write
   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_copy[idx] = value;
   endtask

   task automatic stop_writes();
      csr_write <= 1'b0;
   endtask

   // valid stays up after acceptance until an idle cycle or a drain drops it
   task automatic send_word(input logic restart, input logic known,
                            input result_word_type fixed);
      result_word_type want;
      if (!quiet_mode) begin
         while ($urandom_range(99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_state(restart, want);
      pending_results.push_back(want);
      pending_known.push_back(known);
      pending_fixed.push_back(fixed);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: check on acceptance, then pick the next ready level
   always @(posedge clock) begin
      result_word_type want, fixed;
      logic known;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_elapsed, 0);
            end else begin
               want = pending_results.pop_front();
               known = pending_known.pop_front();
               fixed = pending_fixed.pop_front();
               if (known && fixed != want)
                  report_mismatch("table entry", fixed.elapsed, want.elapsed);
               if (rsp_elapsed !== want.elapsed)
                  report_mismatch("elapsed", rsp_elapsed, want.elapsed);
               if (rsp_pop_one !== want.pop_one)
                  report_mismatch("pop_one", rsp_pop_one, want.pop_one);
               if (rsp_pop_two !== want.pop_two)
                  report_mismatch("pop_two", rsp_pop_two, want.pop_two);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", rsp_saturated, want.saturated);
            end
         end
         rsp_ready <= !hold_off && (quiet_mode || $urandom_range(99) >= 28);
      end
   end

   // watchdog on words moving either way
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (pending_results.size() == 0 && !req_valid))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("two_level_amplitude_stepper_unit: mismatch");
         $finish;
      end
   end

   // long receiver hold-off so the input stalls
   initial begin
      wait (drained);
      hold_off = 1'b1;
      repeat (900) @(posedge clock);
      hold_off = 1'b0;
   end

   stim_row_type directed [$];

   task automatic random_settings(input bit extreme);
      logic [31:0] v;
      for (int r = 0; r < 7; r++) begin
         v = $urandom();
         case (r)
            REG_INIT_ONE, REG_INIT_TWO: if (!extreme) v = $signed(v) >>> $urandom_range(3, 0);
            REG_TIME_STEP: if (!extreme) v = v >> $urandom_range(31, 18);
            default: if (!extreme) v = $signed(v) >>> $urandom_range(24, 12);
         endcase
         write_register(r[2:0], v);
      end
      stop_writes();
   endtask

   initial begin
      result_word_type none, fixed;
      none = '0;
      csr_copy[0] = RESET_INIT_ONE;  csr_copy[1] = RESET_INIT_TWO;
      csr_copy[2] = RESET_RABI_FREQ; csr_copy[3] = RESET_DECAY;
      csr_copy[4] = RESET_TIME_STEP; csr_copy[5] = RESET_DETUNING;
      csr_copy[6] = RESET_LEVEL;
      c1_re = RESET_INIT_ONE; c1_im = 0; c2_re = RESET_INIT_TWO; c2_im = 0;
      clock_time = '0; phase_acc = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // restart after reset: level one full, level two empty
      fixed = '{48'd0, 34'h1000_0000, 34'd0, 1'b0};
      directed.push_back('{1'b1, 1'b1, fixed});
      for (int i = 0; i < 6; i++) directed.push_back('{1'b0, 1'b0, none});
      foreach (directed[i]) send_word(directed[i].restart, directed[i].known,
                                      directed[i].want);
      wait_drained();

      // extremes: the most negative amplitude saturates level two
      write_register(REG_INIT_ONE, 32'h7FFFFFFF);
      write_register(REG_INIT_TWO, 32'h80000000);
      write_register(REG_RABI_FREQ, 32'h7FFFFFFF);
      write_register(REG_DECAY_RATE, 32'h80000000);
      write_register(REG_TIME_STEP, 32'hFFFFFFFF);
      write_register(REG_DETUNING, 32'h7FFFFFFF);
      write_register(REG_LEVEL_FREQ, 32'h80000000);
      stop_writes();
      fixed = '{48'd0, 34'h3_FFFF_FFF0, 34'h3_FFFF_FFFF, 1'b1};
      send_word(1'b1, 1'b1, fixed);
      for (int i = 0; i < 8; i++) send_word(1'b0, 1'b0, none);
      wait_drained();
      // out-of-range index is dropped
      csr_write <= 1'b1; csr_index <= 3'd7; csr_data <= 32'hFFFFFFFF;
      @(posedge clock);
      write_register(REG_INIT_ONE, 32'd0);
      write_register(REG_INIT_TWO, 32'd0);
      write_register(REG_TIME_STEP, 32'd0);
      stop_writes();
      fixed = '{48'd0, 34'd0, 34'd0, 1'b0};
      send_word(1'b1, 1'b1, fixed);
      send_word(1'b0, 1'b0, none);
      wait_drained();

      // random phases; the first has no idling
      quiet_mode = 1'b1;
      for (int ph = 0; ph < 12; ph++) begin
         wait_drained();
         random_settings(ph == 5);
         if (ph == 1) quiet_mode = 1'b0;
         if (ph == 3) drained = 1'b1;
         send_word(1'b1, 1'b0, none);
         for (int i = 0; i < 128; i++)
            send_word($urandom_range(99) < 4, 1'b0, none);
         if (ph == 7) wait_drained();
      end
      wait_drained();
      if (fail_count == 0) begin
         $display("two_level_amplitude_stepper_unit: match");
      end else begin
         $display("two_level_amplitude_stepper_unit: mismatch");
      end
      $finish;
   end

endmodule
